// File: hdl/ecws_pkg.sv
// ----------------------------------------------------------------------------
// Encounter compliance window scorer package
// Shared widths, constants and types for the window scorer and its checker.
// ----------------------------------------------------------------------------
package ecws_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = 7;

    localparam int TIME_W = 32;
    localparam int DIST_W = 20;
    localparam int HDG_W  = 16;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 24;
    localparam int SCORE_W     = 16;

    localparam logic [TIME_W-1:0]  WINDOW_DEFAULT = 32'd30000;
    localparam logic [SCORE_W-1:0] NEUTRAL_SCORE  = 16'd32768;

    localparam int QUO_W  = 16;
    localparam int ITER_W = $clog2(QUO_W);
    localparam int TERM_W = 17;
    localparam int HI_W   = 23;
    localparam int HD_W   = 15;
    localparam int HX_W   = 18;

    localparam logic [TIME_W-1:0] HEADING_DIV = 32'd2000;
    localparam logic [TERM_W-1:0] TERM_HALF   = 17'd32768;
    localparam logic [TERM_W-1:0] TERM_FULL   = 17'd65536;

    localparam int SUM_W    = 23;
    localparam int RECIP_W  = 24;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam int RECIP_SH = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    typedef struct packed {
        logic [HDG_W-1:0]  heading;
        logic [DIST_W-1:0] range_dm;
        logic [DIST_W-1:0] cpa;
        logic [TIME_W-1:0] time_ms;
    } t_sample;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_PRUNE_RD,
        S_PRUNE_CMP,
        S_OLD_RD,
        S_OLD_DAT,
        S_DIV_LOAD,
        S_DIV,
        S_SUM,
        S_MUL,
        S_FIN,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_CPA,
        OP_RANGE,
        OP_HEAD
    } t_div_op;

endpackage

// File: hdl/encounter_compliance_window_scorer_top.sv
// ----------------------------------------------------------------------------
// Encounter compliance window scorer
// A valid sample is stored and samples outside the window are pruned; an
// ignored sample is scored without being stored. With fewer than two held
// samples the score is neutral. One shared restoring divider computes three
// quotients in turn; one item is in work at a time, and the next input
// transfer can be taken in the cycle in which the result appears.
// Reset (synchronous, active low) empties the window and sets window_ms to 30000.
// ----------------------------------------------------------------------------
module encounter_compliance_window_scorer_top
    import ecws_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [TIME_W-1:0]      i_cfg_wr_data,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: sample_time_ms, cpa_dm, range_dm, heading_cdeg
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: sample_valid
    input  logic                   i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata: score_q16, stored_count, zero padding
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_state               r_state, n_state;
    t_div_op              r_op, n_op;
    logic [TIME_W-1:0]    r_window_ms;
    logic [IDX_W-1:0]     r_oldest, n_oldest;
    logic [CNT_W-1:0]     r_total, n_total;

    t_sample              r_in, n_in;
    t_sample              r_new, n_new;

    logic [TIME_W-1:0]    r_dt, n_dt;
    logic                 r_cpa_neg, n_cpa_neg;
    logic                 r_rng_neg, n_rng_neg;
    logic [HI_W-1:0]      r_cpa_hi, n_cpa_hi;
    logic [HI_W-1:0]      r_rng_hi, n_rng_hi;
    logic [HD_W-1:0]      r_hd_hi, n_hd_hi;

    logic [TIME_W-1:0]    r_rem, n_rem;
    logic [QUO_W-1:0]     r_quo, n_quo;
    logic                 r_sat, n_sat;
    logic [ITER_W-1:0]    r_iter, n_iter;

    logic [TERM_W-1:0]    r_term_cpa, n_term_cpa;
    logic [TERM_W-1:0]    r_term_rng, n_term_rng;
    logic [TERM_W-1:0]    r_term_hd, n_term_hd;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [SCORE_W-1:0]   r_score, n_score;

    logic                 r_out_valid, n_out_valid;
    logic [SCORE_W-1:0]   r_out_score, n_out_score;
    logic [CNT_W-1:0]     r_out_count, n_out_count;

    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic                 ram_rd_en;
    t_sample              ram_rd_data;

    logic                 clear_win;
    logic [IDX_W-1:0]     adj_oldest;
    logic [CNT_W-1:0]     adj_total;
    logic [TIME_W-1:0]    win_eff;
    logic [TIME_W-1:0]    old_dt;
    logic [DIST_W-1:0]    cpa_mag;
    logic [DIST_W-1:0]    rng_mag;
    logic [HX_W-1:0]      hx0, hx1, hx2, hx3;
    logic [TIME_W-1:0]    div_d;
    logic [TIME_W-1:0]    div_hi;
    logic [TIME_W:0]      rem2;
    logic                 quo_bit;
    logic [QUO_W-1:0]     quo_full;
    logic [TERM_W-1:0]    prod_q;

    function automatic logic [TERM_W-1:0] trend_term(
        input logic [QUO_W-1:0] q,
        input logic             sat,
        input logic             neg
    );
        logic [TERM_W-1:0] qx;
        logic [TERM_W-1:0] res;
        qx = TERM_W'(q);
        if (neg) begin
            res = (sat || qx >= TERM_HALF) ? '0 : TERM_HALF - qx;
        end else begin
            res = (sat || qx >= TERM_HALF) ? TERM_FULL : qx + TERM_HALF;
        end
        return res;
    endfunction

    ecws_ram #(
        .WIDTH ($bits(t_sample)),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (r_in),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_oldest),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window_ms <= WINDOW_DEFAULT;
            r_oldest    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_window_ms <= i_cfg_wr_data;
            end
        end
        r_op        <= n_op;
        r_in        <= n_in;
        r_new       <= n_new;
        r_dt        <= n_dt;
        r_cpa_neg   <= n_cpa_neg;
        r_rng_neg   <= n_rng_neg;
        r_cpa_hi    <= n_cpa_hi;
        r_rng_hi    <= n_rng_hi;
        r_hd_hi     <= n_hd_hi;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_sat       <= n_sat;
        r_iter      <= n_iter;
        r_term_cpa  <= n_term_cpa;
        r_term_rng  <= n_term_rng;
        r_term_hd   <= n_term_hd;
        r_sum       <= n_sum;
        r_prod      <= n_prod;
        r_score     <= n_score;
        r_out_score <= n_out_score;
        r_out_count <= n_out_count;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_oldest    = r_oldest;
        n_total     = r_total;
        n_in        = r_in;
        n_new       = r_new;
        n_dt        = r_dt;
        n_cpa_neg   = r_cpa_neg;
        n_rng_neg   = r_rng_neg;
        n_cpa_hi    = r_cpa_hi;
        n_rng_hi    = r_rng_hi;
        n_hd_hi     = r_hd_hi;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_sat       = r_sat;
        n_iter      = r_iter;
        n_term_cpa  = r_term_cpa;
        n_term_rng  = r_term_rng;
        n_term_hd   = r_term_hd;
        n_sum       = r_sum;
        n_prod      = r_prod;
        n_score     = r_score;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_score = r_out_score;
        n_out_count = r_out_count;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;

        win_eff = (r_window_ms == '0) ? WINDOW_DEFAULT : r_window_ms;

        clear_win  = (r_total != '0) && (r_in.time_ms < r_new.time_ms);
        adj_oldest = clear_win ? '0 : r_oldest;
        adj_total  = clear_win ? '0 : r_total;
        if (adj_total >= CNT_W'(DEPTH)) begin
            adj_oldest = adj_oldest + IDX_W'(1);
            adj_total  = CNT_W'(DEPTH - 1);
        end
        ram_wr_addr = adj_oldest + adj_total[IDX_W-1:0];

        old_dt  = r_new.time_ms - ram_rd_data.time_ms;
        cpa_mag = (r_new.cpa < ram_rd_data.cpa) ? ram_rd_data.cpa - r_new.cpa
                                                : r_new.cpa - ram_rd_data.cpa;
        rng_mag = (r_new.range_dm < ram_rd_data.range_dm)
                ? ram_rd_data.range_dm - r_new.range_dm
                : r_new.range_dm - ram_rd_data.range_dm;
        hx0 = HX_W'(r_new.heading) + HX_W'(90000) - HX_W'(ram_rd_data.heading);
        hx1 = (hx0 >= HX_W'(144000)) ? hx0 - HX_W'(144000) : hx0;
        hx2 = (hx1 >= HX_W'(72000)) ? hx1 - HX_W'(72000) : hx1;
        hx3 = (hx2 >= HX_W'(36000)) ? hx2 - HX_W'(36000) : hx2;

        div_d = (r_op == OP_HEAD) ? HEADING_DIV : r_dt;
        unique case (r_op)
            OP_CPA:   div_hi = TIME_W'(r_cpa_hi);
            OP_RANGE: div_hi = TIME_W'(r_rng_hi);
            OP_HEAD:  div_hi = TIME_W'(r_hd_hi);
            default:  div_hi = TIME_W'(r_hd_hi);
        endcase
        rem2     = {r_rem, 1'b0};
        quo_bit  = (rem2 >= {1'b0, div_d});
        quo_full = {r_quo[QUO_W-2:0], quo_bit};
        prod_q   = r_prod[PROD_W-1:RECIP_SH];

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_in       = t_sample'(i_s_tdata);
                    n_state    = i_s_tuser ? S_WRITE : S_OLD_RD;
                end
            end
            S_WRITE: begin
                ram_wr_en = 1'b1;
                n_oldest  = adj_oldest;
                n_total   = adj_total + CNT_W'(1);
                n_new     = r_in;
                n_state   = S_PRUNE_RD;
            end
            S_PRUNE_RD: begin
                ram_rd_en = 1'b1;
                n_state   = S_PRUNE_CMP;
            end
            S_PRUNE_CMP: begin
                if (({1'b0, ram_rd_data.time_ms} + {1'b0, win_eff})
                    < {1'b0, r_in.time_ms}) begin
                    n_oldest = r_oldest + IDX_W'(1);
                    n_total  = r_total - CNT_W'(1);
                    n_state  = S_PRUNE_RD;
                end else begin
                    n_state = S_OLD_RD;
                end
            end
            S_OLD_RD: begin
                if (r_total < CNT_W'(2)) begin
                    n_score = NEUTRAL_SCORE;
                    n_state = S_DONE;
                end else begin
                    ram_rd_en = 1'b1;
                    n_state   = S_OLD_DAT;
                end
            end
            S_OLD_DAT: begin
                if ((r_new.time_ms < ram_rd_data.time_ms) || (old_dt == '0)) begin
                    n_score = NEUTRAL_SCORE;
                    n_state = S_DONE;
                end else begin
                    n_dt      = old_dt;
                    n_cpa_neg = r_new.cpa < ram_rd_data.cpa;
                    n_rng_neg = r_new.range_dm < ram_rd_data.range_dm;
                    n_cpa_hi  = HI_W'(cpa_mag) * HI_W'(5);
                    n_rng_hi  = HI_W'(rng_mag) * HI_W'(5);
                    n_hd_hi   = (hx3 >= HX_W'(18000)) ? HD_W'(hx3 - HX_W'(18000))
                                                      : HD_W'(HX_W'(18000) - hx3);
                    n_op      = OP_CPA;
                    n_state   = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD: begin
                n_rem   = div_hi;
                n_sat   = div_hi >= div_d;
                n_quo   = '0;
                n_iter  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = quo_bit ? TIME_W'(rem2 - {1'b0, div_d}) : rem2[TIME_W-1:0];
                n_quo  = quo_full;
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(QUO_W - 1)) begin
                    unique case (r_op)
                        OP_CPA: begin
                            n_term_cpa = trend_term(quo_full, r_sat, r_cpa_neg);
                            n_op       = OP_RANGE;
                            n_state    = S_DIV_LOAD;
                        end
                        OP_RANGE: begin
                            n_term_rng = trend_term(quo_full, r_sat, r_rng_neg);
                            n_op       = OP_HEAD;
                            n_state    = S_DIV_LOAD;
                        end
                        OP_HEAD: begin
                            n_term_hd = r_sat ? TERM_FULL : TERM_W'(quo_full);
                            n_state   = S_SUM;
                        end
                        default: begin
                            n_state = S_SUM;
                        end
                    endcase
                end
            end
            S_SUM: begin
                n_sum   = SUM_W'(r_term_cpa) * SUM_W'(65) + SUM_W'(r_term_rng) * SUM_W'(20)
                        + SUM_W'(r_term_hd) * SUM_W'(15);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_sum) * PROD_W'(RECIP_100);
                n_state = S_FIN;
            end
            S_FIN: begin
                n_score = prod_q[TERM_W-1] ? '1 : prod_q[SCORE_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_score = r_score;
                    n_out_count = r_total;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_count, r_out_score};

endmodule

// File: hdl/ecws_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ecws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/ecws_checker.sv
// ----------------------------------------------------------------------------
// Encounter compliance window scorer checker
// Port-level assertions on the scorer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ecws_checker
    import ecws_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("Result transfer withdrawn before it was taken.");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[22:16] <= CNT_W'(DEPTH)))
        else $error("Stored count exceeds the store depth.");

    a_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[22:16] < 7'd2)) |-> (o_m_tdata[15:0] == NEUTRAL_SCORE))
        else $error("Score is not neutral with fewer than two samples.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("Input accepted again while an item is in work.");

endmodule

bind encounter_compliance_window_scorer_top ecws_checker u_checker (.*);
